/* hdl/gpm_pkg.sv */
`default_nettype none
package gpm_pkg;

	// Field widths of the request and result channels.
	localparam int KIND_W = 2;
	localparam int POS_W = 5;
	localparam int TYPE_W = 2;
	localparam int VAL_W = 8;
	localparam int CLS_W = 3;
	localparam int WSEL_W = 2;
	localparam int CBITS_W = 64;
	localparam int BYTE_W = 8;
	localparam int PLEN_W = 6;

	// Default sizes of the pattern and class stores.
	localparam int MAX_POSITIONS_DEF = 32;
	localparam int NUM_CLASSES_DEF = 8;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_POS = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLASS = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BYTE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_END = 2'd3;

	// Pattern position types.
	localparam logic [TYPE_W-1:0] TYPE_LITERAL = 2'd0;
	localparam logic [TYPE_W-1:0] TYPE_ANY = 2'd1;
	localparam logic [TYPE_W-1:0] TYPE_CLASS = 2'd2;
	localparam logic [TYPE_W-1:0] TYPE_STAR = 2'd3;

	// Control from the request stage to the active set.
	typedef struct packed {
		logic step;    // advance the active set by one subject byte
		logic finish;  // end of subject: report and rearm
	} nfa_ctrl_t;

endpackage
`default_nettype wire

/* hdl/gpm_store.sv */
`default_nettype none
module gpm_store #(
	parameter int MAX_POSITIONS = gpm_pkg::MAX_POSITIONS_DEF,
	parameter int NUM_CLASSES = gpm_pkg::NUM_CLASSES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        wr_pos,
	input  wire logic [gpm_pkg::POS_W-1:0]   position,
	input  wire logic [gpm_pkg::TYPE_W-1:0]  elem_type,
	input  wire logic [gpm_pkg::VAL_W-1:0]   elem_value,
	input  wire logic                        wr_cls,
	input  wire logic [gpm_pkg::CLS_W-1:0]   class_index,
	input  wire logic [gpm_pkg::WSEL_W-1:0]  word_select,
	input  wire logic [gpm_pkg::CBITS_W-1:0] class_bits,
	input  wire logic [gpm_pkg::BYTE_W-1:0]  subject_byte,
	output logic      [MAX_POSITIONS-1:0]    star_vec,
	output logic      [MAX_POSITIONS-1:0]    fit_vec
);
	import gpm_pkg::*;

	localparam int CLASS_BITS = 1 << BYTE_W;

	logic [TYPE_W-1:0]     typ_q [MAX_POSITIONS];
	logic [VAL_W-1:0]      val_q [MAX_POSITIONS];
	logic [CLASS_BITS-1:0] cls_q [NUM_CLASSES];
	logic [CLASS_BITS-1:0] cls_hit;

	// Each entry decodes its own write strobe; an out-of-range position or class hits none.
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_POSITIONS; i++) begin
			if (wr_pos && (int'(position) == i)) begin
				typ_q[i] <= elem_type;
				val_q[i] <= elem_value;
			end
		end
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (wr_cls && (int'(class_index) == c)) begin
				cls_q[c][{word_select, 6'b0} +: CBITS_W] <= class_bits;
			end
		end
	end

	// Membership of the current byte in each class; classes that do not exist never match.
	always_comb begin
		cls_hit = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			cls_hit[c] = cls_q[c][subject_byte];
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_POSITIONS; i++) begin
			star_vec[i] = (typ_q[i] == TYPE_STAR);
			case (typ_q[i])
				TYPE_LITERAL: fit_vec[i] = (val_q[i] == subject_byte);
				TYPE_ANY:     fit_vec[i] = 1'b1;
				TYPE_CLASS:   fit_vec[i] = cls_hit[val_q[i]];
				default:      fit_vec[i] = 1'b0;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/gpm_nfa.sv */
`default_nettype none
module gpm_nfa #(
	parameter int MAX_POSITIONS = gpm_pkg::MAX_POSITIONS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire gpm_pkg::nfa_ctrl_t         ctrl,
	input  wire logic [gpm_pkg::PLEN_W-1:0] pattern_length,
	input  wire logic [MAX_POSITIONS-1:0]   star_vec,
	input  wire logic [MAX_POSITIONS-1:0]   fit_vec,
	output logic                            match
);
	import gpm_pkg::*;

	localparam int N_BITS = MAX_POSITIONS + 1;
	localparam int LEN_W = $clog2(MAX_POSITIONS + 1);
	localparam int N_LEV = $clog2(MAX_POSITIONS + 1);

	logic [N_BITS-1:0]        act_q;
	logic [MAX_POSITIONS-1:0] en;
	logic [N_BITS-1:0]        prop;
	logic [N_BITS-1:0]        cur;
	logic [N_BITS-1:0]        nxt;
	logic [LEN_W-1:0]         used_len;

	always_comb begin
		for (int i = 0; i < MAX_POSITIONS; i++) begin
			en[i] = (int'(pattern_length) > i);
		end
		if (int'(pattern_length) > MAX_POSITIONS) begin
			used_len = LEN_W'(MAX_POSITIONS);
		end else begin
			used_len = LEN_W'(pattern_length);
		end
	end

	// Star closure as a parallel prefix: a bit reaches upwards across a run of active stars.
	always_comb begin
		logic [N_BITS-1:0] g;
		logic [N_BITS-1:0] p;
		logic [N_BITS-1:0] g_n;
		logic [N_BITS-1:0] p_n;
		int d;
		prop[0] = 1'b0;
		for (int i = 1; i < N_BITS; i++) begin
			prop[i] = star_vec[i-1] & en[i-1];
		end
		g = act_q;
		p = prop;
		for (int l = 0; l < N_LEV; l++) begin
			d = 1 << l;
			for (int i = 0; i < N_BITS; i++) begin
				if (i >= d) begin
					g_n[i] = g[i] | (p[i] & g[i-d]);
					p_n[i] = p[i] & p[i-d];
				end else begin
					g_n[i] = g[i];
					p_n[i] = 1'b0;
				end
			end
			g = g_n;
			p = p_n;
		end
		cur = g;
	end

	// One byte step: a star keeps itself, any other position passes on when the byte fits.
	always_comb begin
		nxt = '0;
		for (int i = 0; i < MAX_POSITIONS; i++) begin
			if (cur[i] && en[i]) begin
				if (star_vec[i]) begin
					nxt[i] = 1'b1;
				end else if (fit_vec[i]) begin
					nxt[i+1] = 1'b1;
				end
			end
		end
	end

	assign match = cur[used_len];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= N_BITS'(1);
		end else if (ctrl.finish) begin
			act_q <= N_BITS'(1);
		end else if (ctrl.step) begin
			act_q <= nxt;
		end
	end

endmodule
`default_nettype wire

/* hdl/glob_pattern_matcher.sv */
// Glob pattern matcher.
// Software first loads a compiled glob through the request channel: kind 0 writes one pattern
// position (literal, any byte, bracket class or star), kind 1 writes one 64-bit quarter of a
// bracket class bitmap. The number of positions in use is set through the configuration
// channel (cfg_valid, cfg_ready, cfg_data), which is always ready; it must be written only
// while the block is idle, which the block does not enforce. Subject bytes (kind 2) then
// advance the set of active positions, and an end request (kind 3) yields exactly one
// result, matched, and rearms the matcher. A request is taken at a clock edge where in_valid
// is high and in_stall is low; a result is taken where out_valid is high and out_stall is low.
// Timing: one request per cycle while in_stall is low. A request is fully processed in the
// input register; an end request that completes there loads its result into the output
// register. The depth is set by the byte compare and class lookup feeding the star-closure
// prefix network over all positions.
// If the receiver stalls while a result is held, only an end request waiting in the input
// register is held back (in_stall rises); loads and subject bytes keep flowing.
// Reset (arst_n low) empties both registers, clears the length to zero and leaves only
// position zero active. The pattern and class stores are not cleared and must be loaded
// before use.
`default_nettype none
module glob_pattern_matcher #(
	parameter int MAX_POSITIONS = gpm_pkg::MAX_POSITIONS_DEF,
	parameter int NUM_CLASSES = gpm_pkg::NUM_CLASSES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Configuration write channel.
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [gpm_pkg::PLEN_W-1:0]  cfg_data,
	// Request channel.
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [gpm_pkg::KIND_W-1:0]  kind,
	input  wire logic [gpm_pkg::POS_W-1:0]   position,
	input  wire logic [gpm_pkg::TYPE_W-1:0]  elem_type,
	input  wire logic [gpm_pkg::VAL_W-1:0]   elem_value,
	input  wire logic [gpm_pkg::CLS_W-1:0]   class_index,
	input  wire logic [gpm_pkg::WSEL_W-1:0]  word_select,
	input  wire logic [gpm_pkg::CBITS_W-1:0] class_bits,
	input  wire logic [gpm_pkg::BYTE_W-1:0]  subject_byte,
	// Result channel.
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             matched
);
	import gpm_pkg::*;

	logic                valid_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [POS_W-1:0]    position_s1;
	logic [TYPE_W-1:0]   elem_type_s1;
	logic [VAL_W-1:0]    elem_value_s1;
	logic [CLS_W-1:0]    class_index_s1;
	logic [WSEL_W-1:0]   word_select_s1;
	logic [CBITS_W-1:0]  class_bits_s1;
	logic [BYTE_W-1:0]   subject_byte_s1;

	logic [PLEN_W-1:0]   plen_q;
	logic                out_valid_q;
	logic                matched_q;

	logic                go_s1;
	logic                end_s1;
	nfa_ctrl_t           ctrl;
	logic [MAX_POSITIONS-1:0] star_vec;
	logic [MAX_POSITIONS-1:0] fit_vec;
	logic                match;

	// The configuration register is a plain write target and never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			plen_q <= cfg_data;
		end
	end

	// The request in the input register completes unless it is an end request whose result
	// would overwrite one the receiver has not yet taken.
	assign end_s1 = valid_s1 && (kind_s1 == KIND_END);
	assign go_s1 = valid_s1 && !(end_s1 && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			position_s1 <= position;
			elem_type_s1 <= elem_type;
			elem_value_s1 <= elem_value;
			class_index_s1 <= class_index;
			word_select_s1 <= word_select;
			class_bits_s1 <= class_bits;
			subject_byte_s1 <= subject_byte;
		end
	end

	assign ctrl = '{step: go_s1 && (kind_s1 == KIND_BYTE),
		finish: go_s1 && (kind_s1 == KIND_END)};

	gpm_store #(
		.MAX_POSITIONS(MAX_POSITIONS),
		.NUM_CLASSES(NUM_CLASSES)
	) u_store (
		.clk(clk),
		.wr_pos(go_s1 && (kind_s1 == KIND_POS)),
		.position(position_s1),
		.elem_type(elem_type_s1),
		.elem_value(elem_value_s1),
		.wr_cls(go_s1 && (kind_s1 == KIND_CLASS)),
		.class_index(class_index_s1),
		.word_select(word_select_s1),
		.class_bits(class_bits_s1),
		.subject_byte(subject_byte_s1),
		.star_vec(star_vec),
		.fit_vec(fit_vec)
	);

	gpm_nfa #(
		.MAX_POSITIONS(MAX_POSITIONS)
	) u_nfa (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.pattern_length(plen_q),
		.star_vec(star_vec),
		.fit_vec(fit_vec),
		.match(match)
	);

	// Output register: loaded by a completing end request, emptied when the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			matched_q <= match;
		end
	end

	assign out_valid = out_valid_q;
	assign matched = matched_q;

`ifndef ASSERT_OFF
	// Requests are only held back behind a result the receiver is refusing.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("request stalled without a blocked result");

	// A completing end request always shows a result on the next cycle.
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(end_s1 && !in_stall) |=> out_valid)
		else $error("end request gave no result");

	// A taken result is not shown again unless a new end request completed.
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !ctrl.finish) |=> !out_valid)
		else $error("result repeated");
`endif

endmodule
`default_nettype wire
